@@ rtl/cluster_reassign_linf_cap_macros.svh @@
`ifndef CLUSTER_REASSIGN_LINF_CAP_MACROS_SVH
`define CLUSTER_REASSIGN_LINF_CAP_MACROS_SVH

// check a property on every edge outside reset
`define CRLC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check an implication on every edge outside reset
`define CRLC_ASSERT_IMP(label, cond, prop, msg) \
	`CRLC_ASSERT(label, (cond) |-> (prop), msg)

`endif

@@ rtl/crlc_pkg.sv @@
`default_nettype none

package crlc_pkg;

	localparam int NUM_CLUSTERS   = 256;
	localparam int ROW_LENGTH_MAX = 64;
	localparam int STORE_DEPTH    = NUM_CLUSTERS * ROW_LENGTH_MAX;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);

	localparam int CMD_W     = 2;
	localparam int CLUSTER_W = 8;
	localparam int COLUMN_W  = 6;
	localparam int SAMPLE_W  = 16;
	localparam int DIST_W    = 16;
	localparam int TALLY_W   = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CENTROID = 2'd0,
		CMD_DATA     = 2'd1,
		CMD_START    = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAP_ENABLE   = 1'b0,
		REG_MAX_DISTANCE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                        is_start;
		logic                        last;
		logic                        ok;
		logic [CLUSTER_W-1:0]        tent;
		logic [CLUSTER_W-1:0]        cur;
		logic signed [SAMPLE_W-1:0]  sample;
	} elem_t;

endpackage

`default_nettype wire

@@ rtl/cluster_reassign_linf_cap.sv @@
// A result passes through the s1, s2 and output registers after its last element is accepted.
// Throughput: one item per cycle while item_stall is low; each data element makes one read of the
// centroid memory and each centroid element one write, on separate ports.
// Reset clears the pipeline, the running maximum, the tally and both
// registers; the centroid memory is not cleared and holds no value until written.
`default_nettype none

module cluster_reassign_linf_cap (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [crlc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [crlc_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [crlc_pkg::CMD_W-1:0]          cmd,
	input  wire logic [crlc_pkg::CLUSTER_W-1:0]      cluster_index,
	input  wire logic [crlc_pkg::CLUSTER_W-1:0]      current_cluster,
	input  wire logic [crlc_pkg::COLUMN_W-1:0]       column,
	input  wire logic signed [crlc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [crlc_pkg::CLUSTER_W-1:0]           new_cluster,
	output logic                                     reassigned,
	output logic [crlc_pkg::DIST_W-1:0]              max_abs_diff,
	output logic [crlc_pkg::TALLY_W-1:0]             tally
);

	import crlc_pkg::*;

	logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

	logic cap_enable_q;
	logic [DIST_W-1:0] max_distance_q;
	logic [DIST_W-1:0] run_max_q;
	logic [TALLY_W-1:0] tally_q;

	logic v_s1, v_s2, out_v_q;
	elem_t e_s1, e_s2;
	logic [SAMPLE_W-1:0] rd_s1;
	logic [DIST_W-1:0] mag_s2;

	logic [CLUSTER_W-1:0] new_cluster_q;
	logic reassigned_q;
	logic [DIST_W-1:0] dist_q;

	logic accept, en1, en2, out_load, res2;
	logic in_ok, wr_en, rd_en, enter_s1;
	logic [ADDR_W-1:0] addr;
	logic signed [SAMPLE_W-1:0] cent;
	logic signed [SAMPLE_W:0] diff;
	logic [DIST_W-1:0] mag;
	logic [DIST_W-1:0] new_max;
	logic moved;
	logic [TALLY_W-1:0] tally_next;

	assign out_load   = !out_v_q || !result_stall;
	assign res2       = !e_s2.is_start && e_s2.last;
	assign en2        = !v_s2 || !res2 || out_load;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;
	assign accept     = item_valid && en1;

	assign in_ok = (32'(cluster_index) < NUM_CLUSTERS) && (32'(column) < ROW_LENGTH_MAX);
	assign addr  = ADDR_W'(32'(cluster_index) * ROW_LENGTH_MAX + 32'(column));

	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		enter_s1 = 1'b0;
		unique case (cmd_t'(cmd))
			CMD_CENTROID: begin
				wr_en = accept && in_ok;
			end
			CMD_DATA: begin
				rd_en    = accept;
				enter_s1 = accept;
			end
			CMD_START: begin
				enter_s1 = accept;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= sample;
		end
		if (rd_en) begin
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_enable_q   <= 1'b0;
			max_distance_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CAP_ENABLE:   cap_enable_q   <= cfg_data[0];
				REG_MAX_DISTANCE: max_distance_q <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && enter_s1) begin
			e_s1.is_start <= (cmd_t'(cmd) == CMD_START);
			e_s1.last     <= last;
			e_s1.ok       <= in_ok;
			e_s1.tent     <= cluster_index;
			e_s1.cur      <= current_cluster;
			e_s1.sample   <= sample;
		end
	end

	assign cent = e_s1.ok ? $signed(rd_s1) : '0;
	assign diff = {e_s1.sample[SAMPLE_W-1], e_s1.sample} - {cent[SAMPLE_W-1], cent};
	assign mag  = diff[SAMPLE_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			e_s2   <= e_s1;
			mag_s2 <= mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= enter_s1;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign new_max    = (mag_s2 > run_max_q) ? mag_s2 : run_max_q;
	assign moved      = (e_s2.cur != e_s2.tent) && (!cap_enable_q || new_max <= max_distance_q);
	assign tally_next = (tally_q == TALLY_MAX) ? tally_q : tally_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
			tally_q   <= '0;
		end else if (v_s2 && en2) begin
			if (e_s2.is_start) begin
				run_max_q <= '0;
				tally_q   <= '0;
			end else if (e_s2.last) begin
				run_max_q <= '0;
				if (moved) begin
					tally_q <= tally_next;
				end
			end else begin
				run_max_q <= new_max;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= v_s2 && res2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && v_s2 && res2) begin
			new_cluster_q <= moved ? e_s2.tent : e_s2.cur;
			reassigned_q  <= moved;
			dist_q        <= new_max;
		end
	end

	logic [TALLY_W-1:0] tally_out_q;

	always_ff @(posedge clk) begin
		if (out_load && v_s2 && res2) begin
			tally_out_q <= moved ? tally_next : tally_q;
		end
	end

	assign result_valid = out_v_q;
	assign new_cluster  = new_cluster_q;
	assign reassigned   = reassigned_q;
	assign max_abs_diff = dist_q;
	assign tally        = tally_out_q;

endmodule

`default_nettype wire

@@ rtl/crlc_checker.sv @@
`default_nettype none

`include "cluster_reassign_linf_cap_macros.svh"

module crlc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                item_stall,
	input wire logic                                result_valid,
	input wire logic                                result_stall,
	input wire logic [crlc_pkg::CLUSTER_W-1:0]      new_cluster,
	input wire logic                                reassigned,
	input wire logic [crlc_pkg::DIST_W-1:0]         max_abs_diff,
	input wire logic [crlc_pkg::TALLY_W-1:0]        tally
);

	import crlc_pkg::*;

	`CRLC_ASSERT_IMP(a_result_hold, result_valid && result_stall, ##1 (result_valid && $stable(new_cluster) && $stable(reassigned) && $stable(max_abs_diff) && $stable(tally)), "result changed while stalled")
	`CRLC_ASSERT_IMP(a_move_counted, result_valid && reassigned, tally != '0, "reassignment with zero tally")
	`CRLC_ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall, "input stalled with output free")

endmodule

bind cluster_reassign_linf_cap crlc_checker u_crlc_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crlc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_MAX      = 18;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int PHASE_ITEMS   = 240;

	typedef struct packed {
		logic [CLUSTER_W-1:0] new_cluster;
		logic                 reassigned;
		logic [DIST_W-1:0]    max_abs_diff;
		logic [TALLY_W-1:0]   tally;
	} decision_t;

	class reassign_scoreboard;
		logic signed [SAMPLE_W-1:0] centroid [STORE_DEPTH];
		logic [DIST_W-1:0]          row_max    = '0;
		logic [TALLY_W-1:0]         moves      = '0;
		logic                       cap_on     = 1'b0;
		logic [DIST_W-1:0]          dist_limit = '0;
		decision_t                  decisions_due[$];
		int                         errors     = 0;

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_CAP_ENABLE:   cap_on = data[0];
				REG_MAX_DISTANCE: dist_limit = data[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic [CMD_W-1:0] op, logic [CLUSTER_W-1:0] tent,
				logic [CLUSTER_W-1:0] cur, logic [COLUMN_W-1:0] col,
				logic signed [SAMPLE_W-1:0] smp, logic lst);
			int        mag;
			logic      moved;
			decision_t want;
			case (op)
				CMD_CENTROID: centroid[{tent, col}] = smp;
				CMD_START: begin
					moves   = '0;
					row_max = '0;
				end
				CMD_DATA: begin
					mag = int'(smp) - int'(centroid[{tent, col}]);
					if (mag < 0)
						mag = -mag;
					if (mag > row_max)
						row_max = mag[DIST_W-1:0];
					if (lst) begin
						moved = (cur != tent) && (!cap_on || row_max <= dist_limit);
						if (moved && moves != TALLY_MAX)
							moves++;
						want.new_cluster  = moved ? tent : cur;
						want.reassigned   = moved;
						want.max_abs_diff = row_max;
						want.tally        = moves;
						decisions_due.push_back(want);
						row_max = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_decision(decision_t got);
			decision_t want;
			if (decisions_due.size() == 0) begin
				$error("unexpected result: new_cluster %0d, tally %0d",
					got.new_cluster, got.tally);
				errors++;
				return;
			end
			want = decisions_due.pop_front();
			if (got.new_cluster !== want.new_cluster) begin
				$error("new_cluster: expected %0d, actual %0d",
					want.new_cluster, got.new_cluster);
				errors++;
			end
			if (got.reassigned !== want.reassigned) begin
				$error("reassigned: expected %0d, actual %0d",
					want.reassigned, got.reassigned);
				errors++;
			end
			if (got.max_abs_diff !== want.max_abs_diff) begin
				$error("max_abs_diff: expected %0d, actual %0d",
					want.max_abs_diff, got.max_abs_diff);
				errors++;
			end
			if (got.tally !== want.tally) begin
				$error("tally: expected %0d, actual %0d", want.tally, got.tally);
				errors++;
			end
		endfunction

		function int pending();
			return decisions_due.size();
		endfunction
	endclass

	logic                        clk             = 1'b0;
	logic                        arst_n          = 1'b0;
	logic                        cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index       = '0;
	logic [CFG_W-1:0]            cfg_data        = '0;
	logic                        item_valid      = 1'b0;
	logic                        item_stall;
	logic [CMD_W-1:0]            cmd             = '0;
	logic [CLUSTER_W-1:0]        cluster_index   = '0;
	logic [CLUSTER_W-1:0]        current_cluster = '0;
	logic [COLUMN_W-1:0]         column          = '0;
	logic signed [SAMPLE_W-1:0]  sample          = '0;
	logic                        last            = 1'b0;
	logic                        result_valid;
	logic                        result_stall    = 1'b0;
	logic [CLUSTER_W-1:0]        new_cluster;
	logic                        reassigned;
	logic [DIST_W-1:0]           max_abs_diff;
	logic [TALLY_W-1:0]          tally;

	reassign_scoreboard   sb;
	bit                   tx_quiet;
	bit                   rx_quiet;
	int                   rx_hold;
	bit                   loaded [NUM_CLUSTERS][ROW_LENGTH_MAX];
	bit                   row_seen [NUM_CLUSTERS];
	logic [CLUSTER_W-1:0] loaded_rows[$];
	logic [CLUSTER_W-1:0] hot_rows [8];

	cluster_reassign_linf_cap dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.cmd             (cmd),
		.cluster_index   (cluster_index),
		.current_cluster (current_cluster),
		.column          (column),
		.sample          (sample),
		.last            (last),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.new_cluster     (new_cluster),
		.reassigned      (reassigned),
		.max_abs_diff    (max_abs_diff),
		.tally           (tally)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_hold = 0;
		end else if (result_valid && !result_stall) begin
			sb.check_decision({new_cluster, reassigned, max_abs_diff, tally});
			rx_hold = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
			result_stall <= (rx_hold != 0);
		end else if (rx_hold != 0) begin
			rx_hold--;
			result_stall <= (rx_hold != 0);
		end
	end

	task automatic push_item(logic [CMD_W-1:0] op, logic [CLUSTER_W-1:0] tent,
			logic [CLUSTER_W-1:0] cur, logic [COLUMN_W-1:0] col,
			logic signed [SAMPLE_W-1:0] smp, logic lst);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid      <= 1'b1;
		cmd             <= op;
		cluster_index   <= tent;
		current_cluster <= cur;
		column          <= col;
		sample          <= smp;
		last            <= lst;
		do @(posedge clk); while (item_stall);
		sb.note_item(op, tent, cur, col, smp, lst);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_centroid(logic [CLUSTER_W-1:0] cl, logic [COLUMN_W-1:0] col,
			logic signed [SAMPLE_W-1:0] smp, logic lst);
		if (!row_seen[cl]) begin
			row_seen[cl] = 1'b1;
			loaded_rows.push_back(cl);
		end
		loaded[cl][col] = 1'b1;
		push_item(CMD_CENTROID, cl, CLUSTER_W'($urandom), col, smp, lst);
	endtask

	// only written centroid entries are ever read
	task automatic send_vector(int len, bit closed);
		logic [CLUSTER_W-1:0]       row;
		logic [CLUSTER_W-1:0]       cur;
		logic [COLUMN_W-1:0]        cols[$];
		logic [COLUMN_W-1:0]        col;
		logic signed [SAMPLE_W-1:0] smp;
		int                         lim;
		int                         offs;
		int                         pick;
		row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
		cur = ($urandom_range(0, 3) == 0) ? row : CLUSTER_W'($urandom);
		lim = sb.dist_limit;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
			cols.delete();
			for (int c = 0; c < ROW_LENGTH_MAX; c++)
				if (loaded[row][c])
					cols.push_back(COLUMN_W'(c));
			col  = cols[$urandom_range(0, cols.size() - 1)];
			pick = $urandom_range(0, 9);
			offs = (pick == 0) ? 0 : (pick < 4) ? lim - 1 + $urandom_range(0, 2)
				: $urandom_range(0, lim);
			if ($urandom_range(0, 1))
				offs = -offs;
			if (pick < 7)
				smp = SAMPLE_W'(sb.centroid[{row, col}] + offs);
			else if (pick == 7)
				smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			else
				smp = SAMPLE_W'($urandom);
			push_item(CMD_DATA, row, (i == len - 1) ? cur : CLUSTER_W'($urandom), col, smp,
				closed && (i == len - 1));
		end
	endtask

	initial begin
		int               done_items;
		int               phase_end;
		int               len;
		int               pick;
		logic [CFG_W-1:0] cfg_word;
		sb = new;
		hot_rows[0] = 8'd0;
		hot_rows[1] = 8'd255;
		for (int i = 2; i < 8; i++)
			hot_rows[i] = CLUSTER_W'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_CAP_ENABLE, '0);
		write_reg(REG_MAX_DISTANCE, '0);
		load_centroid(8'd0, 6'd0, 16'sh8000, 1'b0);
		load_centroid(8'd255, 6'd63, 16'sh7FFF, 1'b0);
		load_centroid(8'd0, 6'd63, 16'sh0000, 1'b1);
		load_centroid(8'd255, 6'd0, 16'sh5555, 1'b0);
		push_item(CMD_START, 8'hAA, 8'h55, 6'h2A, 16'sh1234, 1'b1);
		push_item(CMD_UNUSED, 8'hFF, 8'hFF, 6'h3F, 16'shFFFF, 1'b1);
		push_item(CMD_DATA, 8'd0, 8'd255, 6'd0, 16'sh7FFF, 1'b1);
		push_item(CMD_DATA, 8'd255, 8'd255, 6'd63, 16'sh8000, 1'b1);
		// switch tentative cluster mid-row, with an unused command inside the row
		push_item(CMD_DATA, 8'd0, 8'd9, 6'd63, 16'sh0100, 1'b0);
		push_item(CMD_UNUSED, 8'h00, 8'h00, 6'h00, 16'sh0000, 1'b0);
		push_item(CMD_DATA, 8'd255, 8'd9, 6'd0, 16'sh5500, 1'b0);
		push_item(CMD_DATA, 8'd255, 8'd0, 6'd63, 16'sh7FFF, 1'b1);
		load_centroid(8'd7, 6'd5, 16'sh00C0, 1'b0);
		push_item(CMD_DATA, 8'd7, 8'd200, 6'd5, 16'sh00C0, 1'b1);
		// start pass mid-row drops the running maximum
		push_item(CMD_DATA, 8'd0, 8'd1, 6'd0, 16'sh7FFF, 1'b0);
		push_item(CMD_START, 8'd0, 8'd0, 6'd0, 16'sh0000, 1'b0);
		push_item(CMD_DATA, 8'd0, 8'd1, 6'd0, 16'sh8000, 1'b1);
		drain();
		write_reg(REG_CAP_ENABLE, 16'hFFFF);
		push_item(CMD_DATA, 8'd7, 8'd1, 6'd5, 16'sh00C0, 1'b1);
		push_item(CMD_DATA, 8'd7, 8'd1, 6'd5, 16'sh00C1, 1'b1);
		drain();
		write_reg(REG_MAX_DISTANCE, 16'hFFFF);
		push_item(CMD_DATA, 8'd0, 8'd2, 6'd0, 16'sh7FFF, 1'b1);
		drain();
		write_reg(REG_MAX_DISTANCE, 16'h00FF);
		push_item(CMD_DATA, 8'd0, 8'd2, 6'd63, 16'sh00FF, 1'b1);
		push_item(CMD_DATA, 8'd0, 8'd2, 6'd63, 16'shFF00, 1'b1);
		drain();

		done_items = 0;
		for (int phase = 0; done_items < RANDOM_ITEMS; phase++) begin
			drain();
			cfg_word    = CFG_W'($urandom);
			cfg_word[0] = (phase % 4 != 0);
			write_reg(REG_CAP_ENABLE, cfg_word);
			case (phase % 4)
				1:       cfg_word = '0;
				2:       cfg_word = '1;
				3:       cfg_word = CFG_W'($urandom_range(0, 1024));
				default: cfg_word = CFG_W'($urandom);
			endcase
			write_reg(REG_MAX_DISTANCE, cfg_word);
			tx_quiet  = (phase % 3 == 1) || (phase % 5 == 4);
			rx_quiet  = (phase % 3 == 2) || (phase % 5 == 4);
			phase_end = done_items + PHASE_ITEMS;
			while (done_items < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					load_centroid(($urandom_range(0, 3) == 0) ? CLUSTER_W'($urandom)
						: hot_rows[$urandom_range(0, 7)], COLUMN_W'($urandom),
						($urandom_range(0, 9) == 0)
						? ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
						: SAMPLE_W'($urandom), 1'($urandom));
					done_items++;
				end else if (pick < 96) begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, ROW_LENGTH_MAX)
						: $urandom_range(1, 8);
					send_vector(len, pick < 92);
					done_items += len;
				end else if (pick < 98) begin
					push_item(CMD_START, CLUSTER_W'($urandom), CLUSTER_W'($urandom),
						COLUMN_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
					done_items++;
				end else begin
					push_item(CMD_UNUSED, CLUSTER_W'($urandom), CLUSTER_W'($urandom),
						COLUMN_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
				end
			end
		end
		drain();

		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
